>>> hw/rtl/abbe_pkg.sv
// Shared types, constants and the base64 alphabet of the affine byte cipher encoder.
package abbe_pkg;

   localparam int unsigned ByteW = 8;
   localparam int unsigned CharW = 7;
   localparam int unsigned SixW  = 6;
   localparam int unsigned ResW  = 4;
   localparam int unsigned MaxChars = 4;
   localparam int unsigned CountW = 3;

   localparam logic [ByteW-1:0] MultKeyReset = 8'd13;
   localparam logic [ByteW-1:0] AddKeyReset  = 8'd5;

   localparam logic [CharW-1:0] CharPad   = 7'h3D;
   localparam logic [CharW-1:0] CharUpper = 7'h41;
   localparam logic [CharW-1:0] CharLower = 7'h61;
   localparam logic [CharW-1:0] CharDigit = 7'h30;
   localparam logic [CharW-1:0] CharPlus  = 7'h2B;
   localparam logic [CharW-1:0] CharSlash = 7'h2F;

   // Configuration register indexes.
   typedef enum logic {
      CSR_MULT_KEY = 1'b0,
      CSR_ADD_KEY  = 1'b1
   } csr_index_type;

   // Position of the next byte within its three-byte group.
   typedef enum logic [1:0] {
      PHASE_0 = 2'd0,
      PHASE_1 = 2'd1,
      PHASE_2 = 2'd2
   } phase_type;

   // Characters produced by one byte, first character in entry 0.
   typedef struct packed {
      logic [MaxChars-1:0][CharW-1:0] chars;
      logic [CountW-1:0]              count;
      logic                           last;
   } burst_type;

   // Maps a 6-bit group onto the standard base64 alphabet.
   function automatic logic [CharW-1:0] b64_char(input logic [SixW-1:0] six);
      logic [CharW-1:0] ch;
      case (six) inside
         [6'd0:6'd25]:  ch = CharUpper + CharW'(six);
         [6'd26:6'd51]: ch = CharLower + CharW'(6'(six - 6'd26));
         [6'd52:6'd61]: ch = CharDigit + CharW'(6'(six - 6'd52));
         6'd62:         ch = CharPlus;
         default:       ch = CharSlash;
      endcase
      return ch;
   endfunction

endpackage

>>> hw/rtl/abbe_packer.sv
// Affine encipherment and base64 group packing, holding the phase and leftover bits.
module abbe_packer import abbe_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  logic [ByteW-1:0] plain_byte,
   input  logic             in_last,
   input  logic [ByteW-1:0] mult_key,
   input  logic [ByteW-1:0] add_key,
   output burst_type        burst
);

   logic [2*ByteW-1:0] product;
   logic [ByteW-1:0]   cipher;
   phase_type          phase_ff, phase_in;
   logic [ResW-1:0]    residual_ff, residual_in;

   assign product = mult_key * plain_byte;
   assign cipher  = product[ByteW-1:0] + add_key;

   // Next phase and leftover bits.
   always_comb begin
      phase_in    = phase_ff;
      residual_in = residual_ff;
      if (load) begin
         if (in_last) begin
            phase_in    = PHASE_0;
            residual_in = '0;
         end else begin
            case (phase_ff)
               PHASE_1: begin
                  phase_in    = PHASE_2;
                  residual_in = cipher[3:0];
               end
               PHASE_2: begin
                  phase_in    = PHASE_0;
                  residual_in = '0;
               end
               default: begin
                  phase_in    = PHASE_1;
                  residual_in = {2'b00, cipher[1:0]};
               end
            endcase
         end
      end
   end

   // Characters for the byte now presented.
   always_comb begin
      burst.chars = '0;
      burst.last  = in_last;
      case (phase_ff)
         PHASE_1: begin
            burst.chars[0] = b64_char({residual_ff[1:0], cipher[7:4]});
            burst.chars[1] = b64_char({cipher[3:0], 2'b00});
            burst.chars[2] = CharPad;
            burst.count    = in_last ? CountW'(3) : CountW'(1);
         end
         PHASE_2: begin
            burst.chars[0] = b64_char({residual_ff, cipher[7:6]});
            burst.chars[1] = b64_char(cipher[5:0]);
            burst.count    = CountW'(2);
         end
         default: begin
            burst.chars[0] = b64_char(cipher[7:2]);
            burst.chars[1] = b64_char({cipher[1:0], 4'b0000});
            burst.chars[2] = CharPad;
            burst.chars[3] = CharPad;
            burst.count    = in_last ? CountW'(4) : CountW'(1);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PHASE_0;
         residual_ff <= '0;
      end else begin
         phase_ff    <= phase_in;
         residual_ff <= residual_in;
      end
   end

endmodule

>>> hw/rtl/affine_byte_cipher_base64_encoder_core.sv
// Top level of the affine byte cipher with base64 output stream.
//
// Each plaintext byte p arriving on the req_ stream is enciphered as
// (add_key + mult_key * p) mod 256, and the enciphered bytes are cut into 6-bit groups
// that leave on the rsp_ stream as standard base64 ASCII characters, one character per
// beat. A character is sent as soon as its group is complete; a byte marked with tlast
// flushes the partial group, adds up to two '=' pad characters and marks the final
// character of the message with tlast. A byte therefore produces one, two, three or four
// beats: one in the first and second position of a group, two in the third, and up to
// four when it ends a message. The rate is set by the single-character output port: a
// byte holds the port until all of its characters have left, so a long message sends
// four characters for every three bytes, plus any pad characters at its end.
// A byte sits in an input register, is enciphered and packed in one
// pass into a small character buffer, and the buffer drains into the output register;
// a new byte is taken in the same cycle that the buffer hands over its last character,
// so both sides stream without bubbles. The keys are written through the csr_ port
// (index 0 is mult_key, reset 13; index 1 is add_key, reset 5) and must only be
// changed while no message is in flight. Reset clears the group position so that the
// first byte starts a new message.
module affine_byte_cipher_base64_encoder_core import abbe_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   // Plaintext stream.
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,   // [7:0] plain_byte
   input  logic             req_tlast,   // in_last
   // Base64 character stream.
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [7:0]       rsp_tdata,   // [6:0] out_char, [7] zero
   output logic             rsp_tlast,   // out_last
   // Key registers.
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [ByteW-1:0] csr_wdata
);

   logic [ByteW-1:0] mult_key_ff;
   logic [ByteW-1:0] add_key_ff;

   // Input register.
   logic             in_valid_ff;
   logic [ByteW-1:0] in_byte_ff;
   logic             in_last_ff;

   // Character buffer filled by the packer, drained one character per cycle unless stalled.
   logic [MaxChars-1:0][CharW-1:0] chars_ff;
   logic [CountW-1:0]              count_ff;
   logic                           burst_last_ff;

   // Output register.
   logic             rsp_valid_ff;
   logic [CharW-1:0] rsp_char_ff;
   logic             rsp_last_ff;

   burst_type burst;
   logic      req_take;
   logic      move;
   logic      load;

   // A character moves to the output register whenever that register is empty or being
   // emptied this cycle.
   assign move = (count_ff != '0) && (!rsp_valid_ff || rsp_tready);

   // The buffer takes the next byte's characters once it is empty or losing its last one.
   assign load = in_valid_ff &&
                 ((count_ff == '0) || ((count_ff == CountW'(1)) && move));

   assign req_tready = !in_valid_ff || load;
   assign req_take   = req_tvalid && req_tready;

   abbe_packer u_packer (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .plain_byte (in_byte_ff),
      .in_last    (in_last_ff),
      .mult_key   (mult_key_ff),
      .add_key    (add_key_ff),
      .burst      (burst)
   );

   // Key registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mult_key_ff <= MultKeyReset;
         add_key_ff  <= AddKeyReset;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_MULT_KEY: mult_key_ff <= csr_wdata;
            CSR_ADD_KEY:  add_key_ff  <= csr_wdata;
            default:      ;
         endcase
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (load) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   // Character buffer: a load replaces the contents, otherwise a move shifts by one.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (load) begin
         count_ff <= burst.count;
      end else if (move) begin
         count_ff <= count_ff - CountW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         chars_ff      <= burst.chars;
         burst_last_ff <= burst.last;
      end else if (move) begin
         chars_ff <= {{CharW{1'b0}}, chars_ff[MaxChars-1:1]};
      end
   end

   // Output register; the final character of a message carries tlast.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (move) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         rsp_char_ff <= chars_ff[0];
         rsp_last_ff <= burst_last_ff && (count_ff == CountW'(1));
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_char_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule
